FILE: rtl/core/gbcd_pkg.sv
// ----------------------------------------------------------------------------
// Gyro bias calibration package
// Shared widths, item and handshake types, register indexes and the scale
// factor table for the gyro bias calibration unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbcd_pkg;

   // Sample and accumulator widths
   localparam int SampleBits   = 16;
   localparam int AxisCount    = 3;
   localparam int AxisBits     = 2;
   localparam int SumBits      = 24;
   localparam int SqBits       = 2 * SampleBits - 1;
   localparam int SqSumBits    = 39;
   localparam int CountBits    = 8;
   // A run that closes on more samples than the count (count lowered
   // mid-run) pushes offset and noise past the sample range.
   localparam int OffsetBits   = SumBits;
   localparam int NoiseBits    = 19;

   // Configuration registers
   localparam int ScaleBits     = 2;
   localparam int ThrBits       = 8;
   localparam int CsrIndexBits  = 2;
   localparam int CsrDataBits   = 8;
   localparam int MaxCalSamples = 255;
   localparam int CalSamplesRst = 50;

   localparam logic [CsrIndexBits-1:0] CsrGyroScale  = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrCalSamples = 2'd1;
   localparam logic [CsrIndexBits-1:0] CsrThreshold  = 2'd2;

   // Rate datapath
   localparam int DevBits     = OffsetBits + 1;
   localparam int FactorBits  = 20;
   localparam int ProdBits    = DevBits + FactorBits;
   localparam int RndShift    = 16;
   localparam int RndBits     = ProdBits + 1 - RndShift;
   localparam int ThrProdBits = NoiseBits + ThrBits;
   localparam int RateBits    = 21;

   localparam logic signed [RateBits-1:0] RateMax = RateBits'(2 ** (RateBits - 1) - 1);
   localparam logic signed [RateBits-1:0] RateMin = RateBits'(2 ** (RateBits - 1));

   // Closing-run arithmetic
   localparam int DivBits     = 48;
   localparam int DivisorBits = 16;
   localparam int RadBits     = 38;
   localparam int RootBits    = 19;

   // Queue between front and back
   localparam int QueueDepth = 2;

   typedef logic signed [SampleBits-1:0] sample_type;

   typedef enum logic {
      KIND_MEASURE = 1'b0,
      KIND_CAL     = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                             kind;
      logic [AxisCount-1:0][SampleBits-1:0] raw;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic [ScaleBits-1:0] gyro_scale;
      logic [CountBits-1:0] cal_samples;
      logic [ThrBits-1:0]   threshold_multiple;
   } cfg_type;

   typedef struct packed {
      logic                   div_go;
      logic                   root_go;
      logic [DivBits-1:0]     dividend;
      logic [DivisorBits-1:0] divisor;
      logic [RadBits-1:0]     radicand;
   } solve_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [DivBits-1:0]  quotient;
      logic [RootBits-1:0] root;
   } solve_rsp_type;

   // Q16 factor, 1/256 dps per digit, by full-scale code
   function automatic logic [FactorBits-1:0] scale_factor(input logic [ScaleBits-1:0] sel);
      logic [FactorBits-1:0] k;
      case (sel)
         2'd0:    k = FactorBits'(128060);
         2'd1:    k = FactorBits'(256138);
         2'd2:    k = FactorBits'(511487);
         2'd3:    k = FactorBits'(1022991);
         default: k = FactorBits'(128060);
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gbcd_front.sv
// ----------------------------------------------------------------------------
// Gyro bias calibration front end
// Accepts sample beats, classifies them as measure or calibration items and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbcd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic                     op,
   input  gbcd_pkg::sample_type     raw_x,
   input  gbcd_pkg::sample_type     raw_y,
   input  gbcd_pkg::sample_type     raw_z,
   input  logic                     head_pop,
   output gbcd_pkg::queue_head_type head
);
   import gbcd_pkg::*;

   localparam int PtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int LevelBits = $clog2(QueueDepth + 1);

   entry_type             slot_ff [QueueDepth];
   entry_type             entry_in;
   logic [PtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LevelBits-1:0]  level_ff, level_in;
   logic                  push_ok;
   logic                  pop_ok;

   // Classify the beat
   always_comb begin
      entry_in.kind   = op ? KIND_CAL : KIND_MEASURE;
      entry_in.raw[0] = raw_x;
      entry_in.raw[1] = raw_y;
      entry_in.raw[2] = raw_z;
   end

   assign full       = (level_ff == LevelBits'(QueueDepth));
   assign push_ok    = push && !full;
   assign head.valid = (level_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign pop_ok     = head_pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push_ok && !pop_ok) begin
         level_in = level_ff + LevelBits'(1);
      end else if (pop_ok && !push_ok) begin
         level_in = level_ff - LevelBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LevelBits'(QueueDepth))
      else $error("front queue level beyond depth");

endmodule

`default_nettype wire

FILE: rtl/core/gbcd_solve.sv
// ----------------------------------------------------------------------------
// Gyro bias calibration solver
// Shared multi-cycle unit: restoring divider, one quotient bit per cycle, and
// digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbcd_solve (
   input  logic                    clock,
   input  logic                    reset,
   input  gbcd_pkg::solve_req_type req,
   output gbcd_pkg::solve_rsp_type rsp
);
   import gbcd_pkg::*;

   localparam int StepBits    = $clog2(DivBits);
   localparam int RootRemBits = RootBits + 2;
   localparam int RootShBits  = RootBits + 4;

   typedef enum logic [1:0] {
      MODE_DIV  = 2'b01,
      MODE_ROOT = 2'b10
   } solve_mode_type;

   solve_mode_type           mode_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [StepBits-1:0]      step_ff;
   logic [DivBits-1:0]       quo_ff, quo_in;
   logic [DivisorBits-1:0]   rem_ff, rem_in;
   logic [DivisorBits-1:0]   divisor_ff;
   logic [RadBits-1:0]       rad_ff, rad_in;
   logic [RootBits-1:0]      root_ff, root_in;
   logic [RootRemBits-1:0]   rrem_ff, rrem_in;
   logic [DivisorBits:0]     shifted;
   logic [DivisorBits:0]     diff;
   logic                     ge;
   logic [RootShBits-1:0]    rshift;
   logic [RootShBits-1:0]    trial;
   logic [RootShBits-1:0]    rdiff;
   logic                     rge;
   logic                     last_step;

   // Divider step: shift one numerator bit in, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[DivBits-1]};
      diff    = shifted - {1'b0, divisor_ff};
      ge      = (shifted >= {1'b0, divisor_ff});
      rem_in  = ge ? diff[DivisorBits-1:0] : shifted[DivisorBits-1:0];
      quo_in  = {quo_ff[DivBits-2:0], ge};
   end

   // Root step: bring down two radicand bits, try root*4+1
   always_comb begin
      rshift  = {rrem_ff, rad_ff[RadBits-1 -: 2]};
      trial   = RootShBits'({root_ff, 2'b01});
      rdiff   = rshift - trial;
      rge     = (rshift >= trial);
      rrem_in = rge ? rdiff[RootRemBits-1:0] : rshift[RootRemBits-1:0];
      root_in = {root_ff[RootBits-2:0], rge};
      rad_in  = {rad_ff[RadBits-3:0], 2'b00};
   end

   always_comb begin
      case (mode_ff)
         MODE_DIV:  last_step = (step_ff == StepBits'(DivBits - 1));
         MODE_ROOT: last_step = (step_ff == StepBits'(RootBits - 1));
         default:   last_step = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (req.div_go || req.root_go) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.div_go) begin
         mode_ff    <= MODE_DIV;
         step_ff    <= '0;
         quo_ff     <= req.dividend;
         rem_ff     <= '0;
         divisor_ff <= req.divisor;
      end else if (req.root_go) begin
         mode_ff <= MODE_ROOT;
         step_ff <= '0;
         rad_ff  <= req.radicand;
         root_ff <= '0;
         rrem_ff <= '0;
      end else if (busy_ff) begin
         case (mode_ff)
            MODE_DIV: begin
               step_ff <= step_ff + StepBits'(1);
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
            end
            MODE_ROOT: begin
               step_ff <= step_ff + StepBits'(1);
               rad_ff  <= rad_in;
               root_ff <= root_in;
               rrem_ff <= rrem_in;
            end
            default: begin
               step_ff <= '0;
            end
         endcase
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.root     = root_ff;

   a_no_go_busy: assert property (@(posedge clock) disable iff (reset)
      (req.div_go || req.root_go) |-> !busy_ff)
      else $error("solver started while busy");

endmodule

`default_nettype wire

FILE: rtl/core/gbcd_back.sv
// ----------------------------------------------------------------------------
// Gyro bias calibration back end
// Carries out queued items: rate scaling with deadband for measure items,
// accumulation and the closing offset/noise run for calibration items.
// ----------------------------------------------------------------------------
`default_nettype none

module gbcd_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  gbcd_pkg::cfg_type                       cfg,
   input  gbcd_pkg::queue_head_type                head,
   output logic                                    head_pop,
   output gbcd_pkg::solve_req_type                 solve_req,
   input  gbcd_pkg::solve_rsp_type                 solve_rsp,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic signed [gbcd_pkg::RateBits-1:0]    rate_x,
   output logic signed [gbcd_pkg::RateBits-1:0]    rate_y,
   output logic signed [gbcd_pkg::RateBits-1:0]    rate_z,
   output logic                                    calibrated
);
   import gbcd_pkg::*;

   localparam int OfsBits  = SumBits + 1;
   localparam int RoundAdd = 2 ** (RndShift - 1);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_MEAS_DEV  = 13'b0000000000010,
      S_MEAS_MUL  = 13'b0000000000100,
      S_MEAS_OUT  = 13'b0000000001000,
      S_CAL_SQ    = 13'b0000000010000,
      S_CAL_ACC   = 13'b0000000100000,
      S_CL_PREP   = 13'b0000001000000,
      S_OFS_GO    = 13'b0000010000000,
      S_OFS_WAIT  = 13'b0000100000000,
      S_VAR_GO    = 13'b0001000000000,
      S_VAR_WAIT  = 13'b0010000000000,
      S_ROOT_GO   = 13'b0100000000000,
      S_ROOT_WAIT = 13'b1000000000000
   } back_state_type;

   back_state_type state_ff, state_in;
   entry_type      entry_ff;

   // Calibration state
   logic signed [SumBits-1:0]    axis_sum_ff    [AxisCount];
   logic [SqSumBits-1:0]         axis_sq_ff     [AxisCount];
   logic signed [OffsetBits-1:0] axis_offset_ff [AxisCount];
   logic [NoiseBits-1:0]         axis_noise_ff  [AxisCount];
   logic [CountBits-1:0]         cal_count_ff;
   logic                         cal_done_ff;

   // Measure pipeline
   sample_type                   raw_s    [AxisCount];
   logic signed [DevBits-1:0]    dev_in   [AxisCount];
   logic                         neg_in   [AxisCount];
   logic                         neg_ff   [AxisCount];
   logic [DevBits-1:0]           mag_in   [AxisCount];
   logic [DevBits-1:0]           mag_ff   [AxisCount];
   logic [ThrProdBits-1:0]       thr_in   [AxisCount];
   logic [ThrProdBits-1:0]       thr_ff   [AxisCount];
   logic [ProdBits-1:0]          prod_in  [AxisCount];
   logic [ProdBits-1:0]          prod_ff  [AxisCount];
   logic [ProdBits:0]            rnd      [AxisCount];
   logic [RndBits-1:0]           mag_rate [AxisCount];
   logic signed [RateBits-1:0]   rate_in  [AxisCount];
   logic signed [RateBits-1:0]   out_rate_ff [AxisCount];
   logic                         out_valid_ff;
   logic                         out_cal_ff;
   logic                         out_free;
   logic [FactorBits-1:0]        k_sel;

   // Accumulate path
   logic signed [2*SampleBits-1:0] sq_full [AxisCount];
   logic [SqBits-1:0]              sq_ff   [AxisCount];
   logic [CountBits:0]             count_inc;
   logic [CountBits-1:0]           n_eff;
   logic                           close_hit;

   // Closing run
   logic [AxisBits-1:0]          axis_ff;
   logic [CountBits-1:0]         n_ff;
   logic signed [SumBits-1:0]    sum_sel;
   logic [SumBits-1:0]           abs_sum_in;
   logic                         sum_neg_ff;
   logic [DivBits-1:0]           num_in, num_ff;
   logic [DivBits-1:0]           sqr_in, sqr_ff;
   logic [DivBits-1:0]           var_num_in, var_num_ff;
   logic [OfsBits-1:0]           ofs_num_in, ofs_num_ff;
   logic [DivisorBits-1:0]       nsq_in, nsq_ff;
   logic [OffsetBits-1:0]        q_ofs;
   logic signed [OffsetBits-1:0] offset_in;
   logic                         last_axis;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign k_sel     = scale_factor(cfg.gyro_scale);
   assign last_axis = (axis_ff == AxisBits'(AxisCount - 1));

   // Effective sample count: zero counts as one, clamp to the maximum
   always_comb begin
      n_eff = (cfg.cal_samples == '0) ? CountBits'(1) : cfg.cal_samples;
      if (32'(n_eff) > MaxCalSamples) begin
         n_eff = CountBits'(MaxCalSamples);
      end
   end

   assign count_inc = {1'b0, cal_count_ff} + (CountBits + 1)'(1);
   assign close_hit = (count_inc >= {1'b0, n_eff});

   // Per-axis datapath
   always_comb begin
      for (int a = 0; a < AxisCount; a++) begin
         raw_s[a]   = sample_type'(entry_ff.raw[a]);
         dev_in[a]  = DevBits'(raw_s[a])
                      - (cal_done_ff ? DevBits'(axis_offset_ff[a]) : DevBits'(0));
         neg_in[a]  = dev_in[a][DevBits-1];
         mag_in[a]  = neg_in[a] ? (~dev_in[a] + DevBits'(1)) : dev_in[a];
         thr_in[a]  = ThrProdBits'(axis_noise_ff[a]) * ThrProdBits'(cfg.threshold_multiple);
         prod_in[a] = ProdBits'(mag_ff[a]) * ProdBits'(k_sel);
         sq_full[a] = (2 * SampleBits)'(raw_s[a]) * (2 * SampleBits)'(raw_s[a]);

         // Round half away from zero, saturate, then apply the deadband
         rnd[a]      = (ProdBits + 1)'(prod_ff[a]) + (ProdBits + 1)'(RoundAdd);
         mag_rate[a] = rnd[a][ProdBits:RndShift];
         if (ThrProdBits'(mag_ff[a]) < thr_ff[a]) begin
            rate_in[a] = '0;
         end else if (neg_ff[a]) begin
            rate_in[a] = (mag_rate[a] > RndBits'(2 ** (RateBits - 1))) ? RateMin
                         : RateBits'(0) - RateBits'(mag_rate[a]);
         end else begin
            rate_in[a] = (mag_rate[a] > RndBits'(2 ** (RateBits - 1) - 1)) ? RateMax
                         : RateBits'(mag_rate[a]);
         end
      end
   end

   // Closing-run operands for the selected axis
   always_comb begin
      sum_sel    = axis_sum_ff[axis_ff];
      abs_sum_in = sum_sel[SumBits-1] ? (~sum_sel + SumBits'(1)) : sum_sel;
      num_in     = DivBits'(n_ff) * DivBits'(axis_sq_ff[axis_ff]);
      sqr_in     = DivBits'(abs_sum_in) * DivBits'(abs_sum_in);
      ofs_num_in = OfsBits'(abs_sum_in) + OfsBits'(n_ff >> 1);
      nsq_in     = DivisorBits'(n_ff) * DivisorBits'(n_ff);
      var_num_in = (num_ff >= sqr_ff) ? (num_ff - sqr_ff) : '0;
      q_ofs      = solve_rsp.quotient[OffsetBits-1:0];
      offset_in  = sum_neg_ff ? (OffsetBits'(0) - q_ofs) : q_ofs;
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      head_pop  = 1'b0;
      solve_req = '0;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               state_in = (head.entry.kind == KIND_CAL) ? S_CAL_SQ : S_MEAS_DEV;
            end
         end
         S_MEAS_DEV: state_in = S_MEAS_MUL;
         S_MEAS_MUL: state_in = S_MEAS_OUT;
         S_MEAS_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_CAL_SQ:  state_in = S_CAL_ACC;
         S_CAL_ACC: state_in = close_hit ? S_CL_PREP : S_IDLE;
         S_CL_PREP: state_in = S_OFS_GO;
         S_OFS_GO: begin
            solve_req.div_go   = 1'b1;
            solve_req.dividend = DivBits'(ofs_num_ff);
            solve_req.divisor  = DivisorBits'(n_ff);
            state_in           = S_OFS_WAIT;
         end
         S_OFS_WAIT: begin
            if (solve_rsp.done) begin
               state_in = S_VAR_GO;
            end
         end
         S_VAR_GO: begin
            solve_req.div_go   = 1'b1;
            solve_req.dividend = var_num_ff;
            solve_req.divisor  = nsq_ff;
            state_in           = S_VAR_WAIT;
         end
         S_VAR_WAIT: begin
            if (solve_rsp.done) begin
               state_in = S_ROOT_GO;
            end
         end
         S_ROOT_GO: begin
            solve_req.root_go  = 1'b1;
            solve_req.radicand = solve_rsp.quotient[RadBits-1:0];
            state_in           = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (solve_rsp.done) begin
               state_in = last_axis ? S_IDLE : S_CL_PREP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and calibration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         cal_done_ff  <= 1'b0;
         cal_count_ff <= '0;
         axis_ff      <= '0;
         for (int a = 0; a < AxisCount; a++) begin
            axis_sum_ff[a]    <= '0;
            axis_sq_ff[a]     <= '0;
            axis_offset_ff[a] <= '0;
            axis_noise_ff[a]  <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (state_ff == S_MEAS_OUT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end

         if (state_ff == S_CAL_ACC) begin
            for (int a = 0; a < AxisCount; a++) begin
               axis_sum_ff[a] <= axis_sum_ff[a] + SumBits'(raw_s[a]);
               axis_sq_ff[a]  <= axis_sq_ff[a] + SqSumBits'(sq_ff[a]);
            end
            cal_count_ff <= close_hit ? '0 : count_inc[CountBits-1:0];
            axis_ff      <= '0;
         end

         if (state_ff == S_OFS_WAIT && solve_rsp.done) begin
            axis_offset_ff[axis_ff] <= offset_in;
         end

         if (state_ff == S_ROOT_WAIT && solve_rsp.done) begin
            axis_noise_ff[axis_ff] <= solve_rsp.root;
            axis_sum_ff[axis_ff]   <= '0;
            axis_sq_ff[axis_ff]    <= '0;
            if (last_axis) begin
               cal_done_ff <= 1'b1;
            end else begin
               axis_ff <= axis_ff + AxisBits'(1);
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (head_pop) begin
         entry_ff <= head.entry;
      end
      if (state_ff == S_MEAS_DEV) begin
         for (int a = 0; a < AxisCount; a++) begin
            neg_ff[a] <= neg_in[a];
            mag_ff[a] <= mag_in[a];
            thr_ff[a] <= thr_in[a];
         end
      end
      if (state_ff == S_MEAS_MUL) begin
         for (int a = 0; a < AxisCount; a++) begin
            prod_ff[a] <= prod_in[a];
         end
      end
      if (state_ff == S_MEAS_OUT && out_free) begin
         for (int a = 0; a < AxisCount; a++) begin
            out_rate_ff[a] <= rate_in[a];
         end
         out_cal_ff <= cal_done_ff;
      end
      if (state_ff == S_CAL_SQ) begin
         for (int a = 0; a < AxisCount; a++) begin
            sq_ff[a] <= sq_full[a][SqBits-1:0];
         end
      end
      if (state_ff == S_CAL_ACC) begin
         n_ff <= n_eff;
      end
      if (state_ff == S_CL_PREP) begin
         sum_neg_ff <= sum_sel[SumBits-1];
         num_ff     <= num_in;
         sqr_ff     <= sqr_in;
         ofs_num_ff <= ofs_num_in;
         nsq_ff     <= nsq_in;
      end
      if (state_ff == S_OFS_GO) begin
         var_num_ff <= var_num_in;
      end
   end

   assign rsp_empty  = !out_valid_ff;
   assign rate_x     = out_rate_ff[0];
   assign rate_y     = out_rate_ff[1];
   assign rate_z     = out_rate_ff[2];
   assign calibrated = out_cal_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      solve_rsp.done |->
         (state_ff == S_OFS_WAIT || state_ff == S_VAR_WAIT || state_ff == S_ROOT_WAIT))
      else $error("solver result arrived outside a wait state");

   a_run_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT_WAIT && solve_rsp.done && last_axis) |=>
         (cal_done_ff && state_ff == S_IDLE))
      else $error("closing run did not mark calibration done");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MEAS_OUT && out_valid_ff && !rsp_pop) |=> (state_ff == S_MEAS_OUT))
      else $error("measure result left while output register occupied");

endmodule

`default_nettype wire

FILE: rtl/core/gyro_bias_calibrate_deadband_unit.sv
// ----------------------------------------------------------------------------
// Gyro bias calibration unit with noise deadband
// Three-axis gyro offset/noise calibration and rate scaling. Push samples in
// through the req_ queue port; op high marks a calibration sample, op low a
// measure sample. Calibration samples produce no result beat: they add into
// per-axis sums and sums of squares, and the sample that reaches cal_samples
// closes the run, latching each axis's rounded mean as its offset and the
// floor square root of the variance as its noise. Each measure sample yields
// one rsp_ beat: offset-corrected rate in 1/256 dps, rounded half away from
// zero, saturated to 21 bits, and forced to zero where the deviation lies
// inside noise times threshold_multiple. Items are carried out one at a time
// in order behind a two-deep queue, so pushes are taken while the back end
// works until the queue fills. A measure item waits in the back end while the
// result register holds an untaken beat. The closing run uses the shared
// solver: for each axis two 48-step restoring divisions (mean, variance) and a
// 19-step square root.
// Write configuration only while idle; the CSR port has no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_bias_calibrate_deadband_unit (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_op,
   input  logic signed [gbcd_pkg::SampleBits-1:0] req_raw_x,
   input  logic signed [gbcd_pkg::SampleBits-1:0] req_raw_y,
   input  logic signed [gbcd_pkg::SampleBits-1:0] req_raw_z,

   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [gbcd_pkg::RateBits-1:0]   rsp_rate_x,
   output logic signed [gbcd_pkg::RateBits-1:0]   rsp_rate_y,
   output logic signed [gbcd_pkg::RateBits-1:0]   rsp_rate_z,
   output logic                                   rsp_calibrated,

   input  logic                                   csr_wr_en,
   input  logic [gbcd_pkg::CsrIndexBits-1:0]      csr_index,
   input  logic [gbcd_pkg::CsrDataBits-1:0]       csr_wdata
);
   import gbcd_pkg::*;

   logic [ScaleBits-1:0] gyro_scale_ff;
   logic [CountBits-1:0] cal_samples_ff;
   logic [ThrBits-1:0]   thr_mult_ff;
   cfg_type              cfg;
   queue_head_type       head;
   logic                 head_pop;
   solve_req_type        solve_req;
   solve_rsp_type        solve_rsp;

   // Configuration registers; writes to unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_scale_ff  <= '0;
         cal_samples_ff <= CountBits'(CalSamplesRst);
         thr_mult_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CsrGyroScale:  gyro_scale_ff  <= csr_wdata[ScaleBits-1:0];
            CsrCalSamples: cal_samples_ff <= csr_wdata[CountBits-1:0];
            CsrThreshold:  thr_mult_ff    <= csr_wdata[ThrBits-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.gyro_scale         = gyro_scale_ff;
   assign cfg.cal_samples        = cal_samples_ff;
   assign cfg.threshold_multiple = thr_mult_ff;

   // Front: accept and classify beats, queue them
   gbcd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .op       (req_op),
      .raw_x    (req_raw_x),
      .raw_y    (req_raw_y),
      .raw_z    (req_raw_z),
      .head_pop (head_pop),
      .head     (head)
   );

   // Shared divider and square root for the closing run
   gbcd_solve u_solve (
      .clock (clock),
      .reset (reset),
      .req   (solve_req),
      .rsp   (solve_rsp)
   );

   // Back: measure scaling, accumulation, closing run and result register
   gbcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_pop   (head_pop),
      .solve_req  (solve_req),
      .solve_rsp  (solve_rsp),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rate_x     (rsp_rate_x),
      .rate_y     (rsp_rate_y),
      .rate_z     (rsp_rate_z),
      .calibrated (rsp_calibrated)
   );

endmodule

`default_nettype wire
